>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SGDM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SGDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// types, widths and register codes of the sgd momentum update unit
// ----------------------------------------------------------------------------
package sgdm_pkg;

    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int RECIP_SHIFT = 20;
    localparam int PIPE_DEPTH  = 9;

    // coefficient times value, exact
    localparam int MUL_W  = COEF_W + 1 + VAL_W;
    // rounded coefficient product plus gradient
    localparam int TERM_W = VAL_W + 2;
    // lr times the term, exact
    localparam int STEP_W = COEF_W + 1 + TERM_W;
    localparam int WIDE_W = VAL_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV  = 2'd2;

    localparam logic [COEF_W-1:0] LR_RESET = 16'd655;
    localparam logic [COEF_W-1:0] MU_RESET = 16'd58982;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 36'sh0_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -36'sh0_8000_0000;

    typedef struct packed {
        logic [COEF_W-1:0] step_size;
        logic [COEF_W-1:0] momentum;
        logic              nesterov_mode;
    } sgdm_cfg_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[VAL_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[VAL_W-1:0];
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/sgdm_item_if.sv
// ----------------------------------------------------------------------------
// sgdm_item_if
// input channel: one weight element per beat
// ----------------------------------------------------------------------------
interface sgdm_item_if;
    import sgdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] param_value;
    logic signed [VAL_W-1:0] grad_value;

    modport source (output valid, element_index, param_value, grad_value, input ready);
    modport sink   (input valid, element_index, param_value, grad_value, output ready);
endinterface

>>> rtl/sgdm_result_if.sv
// ----------------------------------------------------------------------------
// sgdm_result_if
// output channel: one updated weight per beat
// ----------------------------------------------------------------------------
interface sgdm_result_if;
    import sgdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] updated_value;

    modport source (output valid, out_index, updated_value, input ready);
    modport sink   (input valid, out_index, updated_value, output ready);
endinterface

>>> rtl/sgdm_slot_map.sv
// ----------------------------------------------------------------------------
// sgdm_slot_map
// two-stage reduction of the element index modulo the store depth
// ----------------------------------------------------------------------------
module sgdm_slot_map #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [sgdm_pkg::IDX_W-1:0] index,
    output logic [ADDR_W-1:0]          slot
);
    import sgdm_pkg::*;

    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam int RECIP   = (1 << RECIP_SHIFT) / MAX_ELEMENTS;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [RECIP_W-1:0] MODULUS = RECIP_W'(MAX_ELEMENTS);

    logic [PROD_W-1:0] quot_prod;
    logic [PROD_W-1:0] back_prod;
    logic [IDX_W-1:0]  b_quot_reg;
    logic [IDX_W-1:0]  b_index_reg;
    logic [IDX_W-1:0]  c_rem_reg;
    logic [IDX_W-1:0]  rem_fix;

    // quotient estimate, low by at most one
    assign quot_prod = PROD_W'(index) * PROD_W'(RECIP_C);
    assign back_prod = PROD_W'(b_quot_reg) * PROD_W'(MODULUS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_quot_reg  <= quot_prod[RECIP_SHIFT +: IDX_W];
            b_index_reg <= index;
            c_rem_reg   <= b_index_reg - back_prod[IDX_W-1:0];
        end
    end

    always_comb
    begin
        if (RECIP_W'(c_rem_reg) >= MODULUS)
            rem_fix = c_rem_reg - MODULUS[IDX_W-1:0];
        else
            rem_fix = c_rem_reg;
    end

    assign slot = ADDR_W'(rem_fix);

endmodule

>>> rtl/sgdm_vel_ram.sv
// ----------------------------------------------------------------------------
// sgdm_vel_ram
// velocity store: one read and one write port, zero-fill sweep after reset
// ----------------------------------------------------------------------------
module sgdm_vel_ram #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [sgdm_pkg::VAL_W-1:0] rd_data,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [sgdm_pkg::VAL_W-1:0] wr_data,
    output logic                              busy
);
    import sgdm_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ELEMENTS - 1);

    logic signed [VAL_W-1:0] mem [MAX_ELEMENTS];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [ADDR_W-1:0]       clr_addr_next;
    logic                    clr_busy_reg;
    logic                    clr_busy_next;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                clr_busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // sweep owns the write port until done
    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

>>> rtl/sgdm_weight_step.sv
// ----------------------------------------------------------------------------
// sgdm_weight_step
// weight step stages: plain, classic or nesterov term, lr product, round, subtract, saturate
// ----------------------------------------------------------------------------
module sgdm_weight_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  sgdm_pkg::sgdm_cfg_t               cfg,
    input  logic                              d_valid,
    input  logic [sgdm_pkg::IDX_W-1:0]        d_index,
    input  logic signed [sgdm_pkg::VAL_W-1:0] d_param,
    input  logic signed [sgdm_pkg::VAL_W-1:0] d_grad,
    input  logic signed [sgdm_pkg::VAL_W-1:0] d_vel,
    output logic                              h_valid,
    output logic [sgdm_pkg::IDX_W-1:0]        h_index,
    output logic signed [sgdm_pkg::VAL_W-1:0] h_value
);
    import sgdm_pkg::*;

    localparam logic signed [MUL_W-1:0]  MUL_BIAS  = MUL_W'(1 << (COEF_W - 1));
    localparam logic signed [STEP_W-1:0] STEP_BIAS = STEP_W'(1 << (COEF_W - 1));

    logic                     e_valid_reg;
    logic [IDX_W-1:0]         e_index_reg;
    logic signed [VAL_W-1:0]  e_param_reg;
    logic signed [VAL_W-1:0]  e_grad_reg;
    logic signed [VAL_W-1:0]  e_vel_reg;

    logic                     f_valid_reg;
    logic [IDX_W-1:0]         f_index_reg;
    logic signed [VAL_W-1:0]  f_param_reg;
    logic signed [TERM_W-1:0] f_term_reg;

    logic                     g_valid_reg;
    logic [IDX_W-1:0]         g_index_reg;
    logic signed [VAL_W-1:0]  g_param_reg;
    logic signed [STEP_W-1:0] g_prod_reg;

    logic                     h_valid_reg;
    logic [IDX_W-1:0]         h_index_reg;
    logic signed [VAL_W-1:0]  h_value_reg;

    logic signed [COEF_W:0]   mu_s;
    logic signed [COEF_W:0]   lr_s;
    logic signed [MUL_W-1:0]  nv_prod;
    logic signed [MUL_W-1:0]  nv_biased;
    logic signed [TERM_W-1:0] nv_term;
    logic signed [TERM_W-1:0] term_sel;
    logic signed [STEP_W-1:0] lr_prod;
    logic signed [STEP_W-1:0] step_biased;
    logic signed [WIDE_W-1:0] new_param;

    assign mu_s = $signed({1'b0, cfg.momentum});
    assign lr_s = $signed({1'b0, cfg.step_size});

    // nesterov look-ahead: rounded mu*v' + g kept at full width
    assign nv_prod   = MUL_W'(mu_s) * MUL_W'(e_vel_reg);
    assign nv_biased = nv_prod + MUL_BIAS;
    assign nv_term   = TERM_W'($signed(nv_biased[MUL_W-1:COEF_W])) + TERM_W'(e_grad_reg);

    always_comb
    begin
        if (cfg.momentum == '0)
            term_sel = TERM_W'(e_grad_reg);
        else if (cfg.nesterov_mode)
            term_sel = nv_term;
        else
            term_sel = TERM_W'(e_vel_reg);
    end

    assign lr_prod     = STEP_W'(lr_s) * STEP_W'(f_term_reg);
    assign step_biased = g_prod_reg + STEP_BIAS;
    assign new_param   = WIDE_W'(g_param_reg)
                       - WIDE_W'($signed(step_biased[STEP_W-1:COEF_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_index_reg <= d_index;
            e_param_reg <= d_param;
            e_grad_reg  <= d_grad;
            e_vel_reg   <= d_vel;
            f_index_reg <= e_index_reg;
            f_param_reg <= e_param_reg;
            f_term_reg  <= term_sel;
            g_index_reg <= f_index_reg;
            g_param_reg <= f_param_reg;
            g_prod_reg  <= lr_prod;
            h_index_reg <= g_index_reg;
            h_value_reg <= sat32(new_param);
        end
    end

    assign h_valid = h_valid_reg;
    assign h_index = h_index_reg;
    assign h_value = h_value_reg;

endmodule

>>> rtl/sgd_momentum_update_unit.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update_unit
// sgd weight update with classic or nesterov momentum, one element per beat
//
// item beats carry an element index, its weight and its gradient; each gives
// exactly one result beat with the index and the new weight, in order.
// a result passes stage registers a to d, e to h and the output register;
// with result.ready high and the sweep done one item is taken every cycle.
// the loop that sets this is the velocity read-modify-write: one store read
// and one write per cycle, a back-to-back hit on the same entry takes the
// value from a bypass register. after reset all MAX_ELEMENTS store entries
// (1024 by default) are swept to zero, one a cycle, while item.ready stays low.
// when result.ready is low the result is held in the output register; items
// are still taken until the last stage before it fills, then item.ready drops.
// cfg writes (learning rate, momentum, nesterov select) take effect at once
// and belong in idle periods; momentum zero gives plain sgd and leaves the
// velocity store untouched.
// ----------------------------------------------------------------------------
module sgd_momentum_update_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sgdm_item_if.sink                           item,
    sgdm_result_if.source                       result,
    input  logic                                cfg_wr_en,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sgdm_pkg::*;

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    localparam logic signed [MUL_W-1:0] MUL_BIAS = MUL_W'(1 << (COEF_W - 1));

    sgdm_cfg_t               cfg_reg;

    logic                    adv;
    logic                    ram_busy;
    logic                    accept;

    logic                    a_valid_reg;
    logic [IDX_W-1:0]        a_index_reg;
    logic signed [VAL_W-1:0] a_param_reg;
    logic signed [VAL_W-1:0] a_grad_reg;
    logic                    b_valid_reg;
    logic [IDX_W-1:0]        b_index_reg;
    logic signed [VAL_W-1:0] b_param_reg;
    logic signed [VAL_W-1:0] b_grad_reg;
    logic                    c_valid_reg;
    logic [IDX_W-1:0]        c_index_reg;
    logic signed [VAL_W-1:0] c_param_reg;
    logic signed [VAL_W-1:0] c_grad_reg;
    logic [ADDR_W-1:0]       c_slot;
    logic                    d_valid_reg;
    logic [IDX_W-1:0]        d_index_reg;
    logic signed [VAL_W-1:0] d_param_reg;
    logic signed [VAL_W-1:0] d_grad_reg;
    logic [ADDR_W-1:0]       d_slot_reg;

    logic                    fwd_valid_reg;
    logic [ADDR_W-1:0]       fwd_slot_reg;
    logic signed [VAL_W-1:0] fwd_vel_reg;

    logic signed [VAL_W-1:0] ram_rdata;
    logic signed [VAL_W-1:0] vel_old;
    logic signed [COEF_W:0]  mu_s;
    logic signed [MUL_W-1:0] vel_prod;
    logic signed [MUL_W-1:0] vel_biased;
    logic signed [WIDE_W-1:0] vel_sum;
    logic signed [VAL_W-1:0] vel_new;
    logic                    vel_we;

    logic                    h_valid;
    logic [IDX_W-1:0]        h_index;
    logic signed [VAL_W-1:0] h_value;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_load;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size     <= LR_RESET;
            cfg_reg.momentum      <= MU_RESET;
            cfg_reg.nesterov_mode <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STEP_SIZE: cfg_reg.step_size     <= cfg_data;
                CFG_MOMENTUM:  cfg_reg.momentum      <= cfg_data;
                CFG_NESTEROV:  cfg_reg.nesterov_mode <= cfg_data[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // pipeline moves unless a result waits at the output and the last stage is full
    assign out_load   = !out_valid_reg || result.ready;
    assign adv        = out_load || !h_valid;
    assign item.ready = adv && !ram_busy;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            fwd_valid_reg <= vel_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_index_reg  <= item.element_index;
            a_param_reg  <= item.param_value;
            a_grad_reg   <= item.grad_value;
            b_index_reg  <= a_index_reg;
            b_param_reg  <= a_param_reg;
            b_grad_reg   <= a_grad_reg;
            c_index_reg  <= b_index_reg;
            c_param_reg  <= b_param_reg;
            c_grad_reg   <= b_grad_reg;
            d_index_reg  <= c_index_reg;
            d_param_reg  <= c_param_reg;
            d_grad_reg   <= c_grad_reg;
            d_slot_reg   <= c_slot;
            fwd_slot_reg <= d_slot_reg;
            fwd_vel_reg  <= vel_new;
        end
    end

    sgdm_slot_map #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_slot_map (
        .clk   (clk),
        .adv   (adv),
        .index (a_index_reg),
        .slot  (c_slot)
    );

    sgdm_vel_ram #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_vel_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (c_slot),
        .rd_data (ram_rdata),
        .wr_en   (vel_we),
        .wr_addr (d_slot_reg),
        .wr_data (vel_new),
        .busy    (ram_busy)
    );

    // entry written by the previous item is not yet in the read data
    assign vel_old = (fwd_valid_reg && fwd_slot_reg == d_slot_reg) ? fwd_vel_reg : ram_rdata;

    assign mu_s       = $signed({1'b0, cfg_reg.momentum});
    assign vel_prod   = MUL_W'(mu_s) * MUL_W'(vel_old);
    assign vel_biased = vel_prod + MUL_BIAS;
    assign vel_sum    = WIDE_W'($signed(vel_biased[MUL_W-1:COEF_W])) + WIDE_W'(d_grad_reg);
    assign vel_new    = sat32(vel_sum);
    assign vel_we     = adv && d_valid_reg && (cfg_reg.momentum != '0);

    sgdm_weight_step u_weight_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg_reg),
        .d_valid (d_valid_reg),
        .d_index (d_index_reg),
        .d_param (d_param_reg),
        .d_grad  (d_grad_reg),
        .d_vel   (vel_new),
        .h_valid (h_valid),
        .h_index (h_index),
        .h_value (h_value)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= h_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= h_index;
            out_value_reg <= h_value;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_index     = out_index_reg;
    assign result.updated_value = out_value_reg;

endmodule

>>> rtl/sgdm_checker.sv
// ----------------------------------------------------------------------------
// sgdm_checker
// port-level checks of the update unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgdm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [sgdm_pkg::IDX_W-1:0]        out_index,
    input logic signed [sgdm_pkg::VAL_W-1:0] updated_value
);
    import sgdm_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = item_valid && item_ready;
    assign out_beat = result_valid && result_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
            inflight_next = inflight_reg + CNT_W'(1);
        else if (out_beat && !in_beat)
            inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    `SGDM_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(out_index) && $stable(updated_value), "result beat changed while stalled")
    `SGDM_ASSERT_IMPL(a_no_orphan, clk, rst_n, result_valid, inflight_reg != '0, "result beat without an item in flight")
    `SGDM_ASSERT_IMPL(a_capacity, clk, rst_n, 1'b1, inflight_reg <= CNT_W'(PIPE_DEPTH), "more items in flight than pipeline stages")
    `SGDM_ASSERT_IMPL(a_full_stall, clk, rst_n, inflight_reg == CNT_W'(PIPE_DEPTH) && !out_beat, !item_ready, "item taken while pipeline full and stalled")

endmodule

bind sgd_momentum_update_unit sgdm_checker u_sgdm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .out_index     (result.out_index),
    .updated_value (result.updated_value)
);
